// ----- src/otsu_threshold_from_frame_unit_defines.svh -----
// Assertion helpers, clocked on clk, disabled while rst_n is low.
`ifndef OTSU_THRESHOLD_FROM_FRAME_UNIT_DEFINES_SVH
`define OTSU_THRESHOLD_FROM_FRAME_UNIT_DEFINES_SVH

// same-cycle implication
`define OTSU_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OTSU_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/otsu_pkg.sv -----
`default_nettype none
package otsu_pkg;
  localparam int CountWidthDef = 22;
  localparam int Bins          = 256;
  localparam int BinAw         = 8;
  localparam logic [7:0] TopBin = 8'd255;
  localparam logic [7:0] LastT  = 8'd254;
  localparam int FramePixW     = 22;
  localparam int QDepth        = 4;
  localparam int QAw           = 2;

  typedef struct packed {
    logic       last;
    logic [7:0] pixel;
  } pix_word_t;
endpackage
`default_nettype wire

// ----- src/otsu_threshold_from_frame_unit.sv -----
`default_nettype none
// Histogram update: read then write of the bin RAM per pixel (IDLE, PXRD); a 4-word input
// queue absorbs short bursts, and a pixel is popped only once the previous write is done.
// Frame end: thresholds 0..254 are scanned, each read (TRD), accumulated (TACC) and checked
// (TCHK), plus six shift-add multiplies if both classes hold pixels; stops on empty foreground.
// Reset (rst_n low, synchronous): clears queue, histogram valid bits, counters and output.
module otsu_threshold_from_frame_unit
  import otsu_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] pixel
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [7:0] threshold, [29:8] frame_pixels, [31:30] zero
);
  logic                 q_valid;
  pix_word_t            q_word;
  logic                 q_pop;
  logic [7:0]           out_thr;
  logic [FramePixW-1:0] out_pix;

  otsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop)
  );

  otsu_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_word     (q_word),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_thr    (out_thr),
    .out_pix    (out_pix)
  );

  assign out_tdata = {2'b00, out_pix, out_thr};
endmodule
`default_nettype wire

// ----- src/otsu_ram.sv -----
`default_nettype none
module otsu_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]              rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/otsu_mul.sv -----
`default_nettype none
module otsu_mul #(
  parameter int AW = 136,
  parameter int BW = 68,
  parameter int PW = 196
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [AW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic               done,
  output logic [PW-1:0]      p
);
  logic          busy_r;
  logic          done_r;
  logic [PW-1:0] acc_r;
  logic [PW-1:0] a_sh_r;
  logic [BW-1:0] b_sh_r;

  // shift-add, one multiplier bit per cycle, stops when no bits remain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        acc_r  <= '0;
        a_sh_r <= PW'(a);
        b_sh_r <= b;
      end else if (busy_r) begin
        if (b_sh_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (b_sh_r[0]) begin
            acc_r <= acc_r + a_sh_r;
          end
          a_sh_r <= {a_sh_r[PW-2:0], 1'b0};
          b_sh_r <= {1'b0, b_sh_r[BW-1:1]};
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule
`default_nettype wire

// ----- src/otsu_front.sv -----
`default_nettype none
module otsu_front
  import otsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  output logic            q_valid,
  output pix_word_t       q_word,
  input  wire logic       q_pop
);
  pix_word_t        q_mem_r [QDepth];
  logic [QAw-1:0]   wr_ptr_r;
  logic [QAw-1:0]   rd_ptr_r;
  logic [QAw:0]     cnt_r;
  logic             push;
  pix_word_t        w_in;

  assign in_tready = (cnt_r != (QAw+1)'(QDepth));
  assign push      = in_tvalid && in_tready;
  assign w_in.last  = in_tlast;
  assign w_in.pixel = in_tdata;
  assign q_valid   = (cnt_r != '0);
  assign q_word    = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        q_mem_r[wr_ptr_r] <= w_in;
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/otsu_back.sv -----
`default_nettype none
`include "otsu_threshold_from_frame_unit_defines.svh"
module otsu_back
  import otsu_pkg::*;
#(
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire pix_word_t            q_word,
  output logic                      q_pop,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [7:0]                out_thr,
  output logic [FramePixW-1:0]      out_pix
);
  localparam int CW   = COUNT_WIDTH;
  localparam int CTW  = CW + 8;
  localparam int STW  = CW + 16;
  localparam int DW   = 2*CW + 24;
  localparam int NW   = 4*CW + 48;
  localparam int DENW = 2*CW + 16;
  localparam int PW   = 6*CW + 64;
  localparam int MW   = (CW > FramePixW) ? CW : FramePixW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PXRD = 4'd1;
  localparam logic [3:0] ST_TRD  = 4'd2;
  localparam logic [3:0] ST_TACC = 4'd3;
  localparam logic [3:0] ST_TCHK = 4'd4;
  localparam logic [3:0] ST_M1   = 4'd5;
  localparam logic [3:0] ST_M2   = 4'd6;
  localparam logic [3:0] ST_M3   = 4'd7;
  localparam logic [3:0] ST_M4   = 4'd8;
  localparam logic [3:0] ST_M5   = 4'd9;
  localparam logic [3:0] ST_M6   = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;

  logic [3:0]      state_r;
  logic [7:0]      pix_r;
  logic            last_r;
  logic [7:0]      t_r;
  logic [CTW-1:0]  tc_r, cb_r, cf_r;
  logic [STW-1:0]  ts_r, sb_r, sf_r;
  logic [CW-1:0]   pcnt_r;
  logic [DW-1:0]   p1_r, diff_r;
  logic [NW-1:0]   num_r, best_num_r;
  logic [DENW-1:0] den_r, best_den_r;
  logic [PW-1:0]   lhs_r;
  logic [7:0]      best_t_r;
  logic [Bins-1:0] vld_r;
  logic            rd_vld_r;
  logic            mul_go_r;
  logic            out_valid_r;
  logic [7:0]      out_thr_r;
  logic [FramePixW-1:0] out_pix_r;

  logic            ram_we;
  logic [BinAw-1:0] ram_raddr;
  logic [CW-1:0]   ram_rdata;
  logic [CW-1:0]   cnt;
  logic            cnt_sat;
  logic [CW+7:0]   tprod;
  logic [CTW-1:0]  cf_c;
  logic [STW-1:0]  sf_c;
  logic [DW-1:0]   p2;
  logic            last_t;
  logic            ld_out;
  logic            mul_done;
  logic [PW-1:0]   mul_p;
  logic [NW-1:0]   mul_a;
  logic [DW-1:0]   mul_b;
  logic [MW-1:0]   pcnt_ext;
  logic [MW-1:0]   pmax_ext;

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign ram_raddr = (state_r == ST_IDLE) ? q_word.pixel : t_r;
  assign cnt       = rd_vld_r ? ram_rdata : '0;
  assign cnt_sat   = &cnt;
  assign ram_we    = (state_r == ST_PXRD) && !cnt_sat;
  assign tprod     = {{CW{1'b0}}, t_r} * {8'd0, cnt};
  assign cf_c      = tc_r - cb_r;
  assign sf_c      = ts_r - sb_r;
  assign p2        = mul_p[DW-1:0];
  assign last_t    = (t_r == LastT);
  assign ld_out    = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign pcnt_ext  = MW'(pcnt_r);
  assign pmax_ext  = MW'({FramePixW{1'b1}});

  otsu_ram #(.W(CW), .D(Bins)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pix_r),
    .wdata (cnt + 1'b1),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_M1: begin
        mul_a = NW'(sb_r);
        mul_b = DW'(cf_r);
      end
      ST_M2: begin
        mul_a = NW'(sf_r);
        mul_b = DW'(cb_r);
      end
      ST_M3: begin
        mul_a = NW'(diff_r);
        mul_b = diff_r;
      end
      ST_M4: begin
        mul_a = NW'(cb_r);
        mul_b = DW'(cf_r);
      end
      ST_M5: begin
        mul_a = num_r;
        mul_b = DW'(best_den_r);
      end
      ST_M6: begin
        mul_a = best_num_r;
        mul_b = DW'(den_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  otsu_mul #(.AW(NW), .BW(DW), .PW(PW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go_r),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      mul_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pcnt_r      <= '0;
      tc_r        <= '0;
      ts_r        <= '0;
    end else begin
      rd_vld_r <= vld_r[ram_raddr];
      mul_go_r <= 1'b0;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            pix_r   <= q_word.pixel;
            last_r  <= q_word.last;
            state_r <= ST_PXRD;
          end
        end
        ST_PXRD: begin
          if (!cnt_sat) begin
            vld_r[pix_r] <= 1'b1;
            if (pix_r != TopBin) begin
              tc_r <= tc_r + 1'b1;
              ts_r <= ts_r + STW'(pix_r);
            end
          end
          if (!(&pcnt_r)) begin
            pcnt_r <= pcnt_r + 1'b1;
          end
          if (last_r) begin
            t_r        <= '0;
            cb_r       <= '0;
            sb_r       <= '0;
            best_num_r <= '0;
            best_den_r <= DENW'(1);
            best_t_r   <= '0;
            state_r    <= ST_TRD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_TRD: begin
          state_r <= ST_TACC;
        end
        ST_TACC: begin
          cb_r    <= cb_r + CTW'(cnt);
          sb_r    <= sb_r + STW'(tprod);
          state_r <= ST_TCHK;
        end
        ST_TCHK: begin
          if (cb_r == '0) begin
            if (last_t) begin
              state_r <= ST_DONE;
            end else begin
              t_r     <= t_r + 1'b1;
              state_r <= ST_TRD;
            end
          end else if (cf_c == '0) begin
            state_r <= ST_DONE;
          end else begin
            cf_r     <= cf_c;
            sf_r     <= sf_c;
            mul_go_r <= 1'b1;
            state_r  <= ST_M1;
          end
        end
        ST_M1: begin
          if (mul_done) begin
            p1_r     <= mul_p[DW-1:0];
            mul_go_r <= 1'b1;
            state_r  <= ST_M2;
          end
        end
        ST_M2: begin
          if (mul_done) begin
            diff_r   <= (p1_r >= p2) ? (p1_r - p2) : (p2 - p1_r);
            mul_go_r <= 1'b1;
            state_r  <= ST_M3;
          end
        end
        ST_M3: begin
          if (mul_done) begin
            num_r    <= mul_p[NW-1:0];
            mul_go_r <= 1'b1;
            state_r  <= ST_M4;
          end
        end
        ST_M4: begin
          if (mul_done) begin
            den_r    <= mul_p[DENW-1:0];
            mul_go_r <= 1'b1;
            state_r  <= ST_M5;
          end
        end
        ST_M5: begin
          if (mul_done) begin
            lhs_r    <= mul_p;
            mul_go_r <= 1'b1;
            state_r  <= ST_M6;
          end
        end
        ST_M6: begin
          if (mul_done) begin
            if (lhs_r > mul_p) begin
              best_num_r <= num_r;
              best_den_r <= den_r;
              best_t_r   <= t_r;
            end
            if (last_t) begin
              state_r <= ST_DONE;
            end else begin
              t_r     <= t_r + 1'b1;
              state_r <= ST_TRD;
            end
          end
        end
        ST_DONE: begin
          if (ld_out) begin
            out_thr_r <= best_t_r;
            out_pix_r <= (pcnt_ext > pmax_ext) ? {FramePixW{1'b1}}
                                               : pcnt_ext[FramePixW-1:0];
            vld_r     <= '0;
            pcnt_r    <= '0;
            tc_r      <= '0;
            ts_r      <= '0;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_thr    = out_thr_r;
  assign out_pix    = out_pix_r;

  `OTSU_AST_IMP(a_mul_in_scan, mul_done, (state_r == ST_M1) || (state_r == ST_M2) || (state_r == ST_M3) || (state_r == ST_M4) || (state_r == ST_M5) || (state_r == ST_M6), "multiplier result outside scan")
  `OTSU_AST_NXT(a_hist_cleared, ld_out, (vld_r == '0) && (pcnt_r == '0), "histogram not cleared after frame")
  `OTSU_AST_IMP(a_class_order, (state_r == ST_TCHK), (tc_r >= cb_r) && (ts_r >= sb_r), "background exceeds total")
endmodule
`default_nettype wire
